@@ design/pidt_pkg.sv @@
package pidt_pkg;

  // Data format: signed fixed point, fraction width set on the top level
  localparam int DataWidth = 32;

  typedef logic signed [DataWidth-1:0] data_t;

  localparam data_t DataMax = {1'b0, {(DataWidth-1){1'b1}}};
  localparam data_t DataMin = {1'b1, {(DataWidth-1){1'b0}}};

  // Register map, one word per register
  localparam int RegIdxWidth  = 3;
  localparam int PaddrWidth   = RegIdxWidth + 2;
  localparam int PdataWidth   = 32;

  typedef enum logic [RegIdxWidth-1:0] {
    RegKp    = 3'd0,
    RegKd    = 3'd1,
    RegKi    = 3'd2,
    RegUpper = 3'd3,
    RegLower = 3'd4
  } pidt_reg_e;

  // Request and response payloads
  typedef struct packed {
    data_t measured;
    data_t target;
  } pidt_req_t;

  typedef struct packed {
    data_t drive;
    logic  clamped;
  } pidt_rsp_t;

  // Gains and limits as seen by the datapath
  typedef struct packed {
    data_t kp;
    data_t kd_scaled;
    data_t ki_scaled;
    data_t upper_limit;
    data_t lower_limit;
  } pidt_cfg_t;

  // Loop state carried from one sample to the next
  typedef struct packed {
    data_t integral_sum;
    data_t last_error;
    data_t last_derivative;
    logic  saturated_flag;
  } pidt_state_t;

  // Saturate an elaboration-time value to the data range
  function automatic data_t sat_const(longint v);
    data_t r;
    if (v > longint'(DataMax)) begin
      r = DataMax;
    end else if (v < longint'(DataMin)) begin
      r = DataMin;
    end else begin
      r = data_t'(v);
    end
    return r;
  endfunction

endpackage

@@ design/pidt_core.sv @@
module pidt_core #(
  parameter int FRAC_BITS = 16
) (
  input  pidt_pkg::pidt_cfg_t   cfg_i,
  input  pidt_pkg::pidt_state_t state_i,
  input  pidt_pkg::pidt_req_t   req_i,
  output pidt_pkg::pidt_rsp_t   rsp_o,
  output pidt_pkg::pidt_state_t state_o
);
  import pidt_pkg::*;

  localparam int W  = DataWidth;
  localparam int PW = 2 * W;
  localparam int QW = PW - FRAC_BITS;

  // Saturating add
  function automatic data_t sat_add(data_t a, data_t b);
    logic signed [W:0] s;
    data_t r;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      r = s[W] ? DataMin : DataMax;
    end else begin
      r = s[W-1:0];
    end
    return r;
  endfunction

  // Saturating subtract
  function automatic data_t sat_sub(data_t a, data_t b);
    logic signed [W:0] s;
    data_t r;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) begin
      r = s[W] ? DataMin : DataMax;
    end else begin
      r = s[W-1:0];
    end
    return r;
  endfunction

  // Fixed-point product, floor of the scaled result, then saturate
  function automatic data_t fix_mul(data_t a, data_t b);
    logic signed [PW-1:0] prod;
    logic signed [QW-1:0] q;
    data_t r;
    prod = a * b;
    q    = prod[PW-1:FRAC_BITS];
    if ((&q[QW-1:W-1]) || !(|q[QW-1:W-1])) begin
      r = q[W-1:0];
    end else begin
      r = q[QW-1] ? DataMin : DataMax;
    end
    return r;
  endfunction

  data_t err;
  data_t p_term;
  data_t d_diff;
  data_t d_term;
  data_t i_sum;
  data_t i_term;
  data_t pi_sum;
  data_t total;

  // Error and the three terms
  always_comb begin
    err    = sat_sub(req_i.target, req_i.measured);
    p_term = fix_mul(cfg_i.kp, err);
    d_diff = sat_sub(err, state_i.last_error);
    d_term = sat_sub(fix_mul(cfg_i.kd_scaled, d_diff), state_i.last_derivative);
    i_sum  = sat_add(err, state_i.last_error);
    i_term = state_i.saturated_flag ? '0
           : sat_add(state_i.integral_sum, fix_mul(cfg_i.ki_scaled, i_sum));
    pi_sum = sat_add(p_term, i_term);
    total  = sat_add(pi_sum, d_term);
  end

  // Clamp, upper limit first
  always_comb begin
    priority if (total > cfg_i.upper_limit) begin
      rsp_o.drive   = cfg_i.upper_limit;
      rsp_o.clamped = 1'b1;
    end else if (total < cfg_i.lower_limit) begin
      rsp_o.drive   = cfg_i.lower_limit;
      rsp_o.clamped = 1'b1;
    end else begin
      rsp_o.drive   = total;
      rsp_o.clamped = 1'b0;
    end
  end

  // Next loop state
  always_comb begin
    state_o.integral_sum    = i_term;
    state_o.last_error      = err;
    state_o.last_derivative = d_term;
    state_o.saturated_flag  = rsp_o.clamped;
  end

endmodule

@@ design/pid_tustin_conditional_integral.sv @@
// Discrete PID controller in Tustin form with conditional integration. Each
// request carries a measured value and a setpoint in signed fixed point; the
// block returns the clamped drive and a flag telling whether the clamp acted.
// The integral is held at zero for one sample after a clamped output. One
// request is taken per clock cycle while the response path is not stalled.
// Each accepted request is held in the input register, and its response is
// loaded into the response register when that register is free or drained.
// The whole sample, three parallel multiplies, the saturating sums and the
// clamp, runs combinationally from the input register to the response
// register, since the next sample needs the loop state this one leaves; that
// path sets the clock rate. Gains and limits are to be written over the APB
// port only while no request is in flight; the block does not enforce this.
module pid_tustin_conditional_integral #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  pidt_pkg::pidt_req_t                   in_req_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output pidt_pkg::pidt_rsp_t                   out_rsp_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [pidt_pkg::PaddrWidth-1:0]       paddr,
  input  logic [pidt_pkg::PdataWidth-1:0]       pwdata,
  output logic [pidt_pkg::PdataWidth-1:0]       prdata,
  output logic                                  pready
);
  import pidt_pkg::*;

  // Reset values of the gains and limits
  localparam longint One      = longint'(1) << FRAC_BITS;
  localparam longint KiRaw    = (One * 5 + 50) / 100;
  localparam data_t  KpRst    = sat_const(One);
  localparam data_t  KdRst    = sat_const(20 * One);
  localparam data_t  KiRst    = sat_const(KiRaw);
  localparam data_t  UpperRst = sat_const(10 * One);
  localparam data_t  LowerRst = sat_const(-10 * One);

  pidt_cfg_t   cfg_q;
  pidt_state_t state_q;
  pidt_state_t state_d;
  logic        s_valid_q;
  pidt_req_t   req_q;
  logic        out_valid_q;
  pidt_rsp_t   rsp_q;
  pidt_rsp_t   rsp_d;
  logic        accept;
  logic        advance;
  logic        cfg_wr;
  logic [RegIdxWidth-1:0] reg_idx;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[PaddrWidth-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp          <= KpRst;
      cfg_q.kd_scaled   <= KdRst;
      cfg_q.ki_scaled   <= KiRst;
      cfg_q.upper_limit <= UpperRst;
      cfg_q.lower_limit <= LowerRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegKp:    cfg_q.kp          <= pwdata;
        RegKd:    cfg_q.kd_scaled   <= pwdata;
        RegKi:    cfg_q.ki_scaled   <= pwdata;
        RegUpper: cfg_q.upper_limit <= pwdata;
        RegLower: cfg_q.lower_limit <= pwdata;
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      RegKp:    prdata = cfg_q.kp;
      RegKd:    prdata = cfg_q.kd_scaled;
      RegKi:    prdata = cfg_q.ki_scaled;
      RegUpper: prdata = cfg_q.upper_limit;
      RegLower: prdata = cfg_q.lower_limit;
      default:  prdata = '0;
    endcase
  end

  // Handshake: advance into the response register when it is free or drained
  assign advance    = s_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s_valid_q   <= accept || (s_valid_q && !advance);
      out_valid_q <= advance || (out_valid_q && out_stall_i);
    end
  end

  // Hold the request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
  end

  // Datapath for one sample
  pidt_core #(
    .FRAC_BITS(FRAC_BITS)
  ) u_core (
    .cfg_i  (cfg_q),
    .state_i(state_q),
    .req_i  (req_q),
    .rsp_o  (rsp_d),
    .state_o(state_d)
  );

  // Update loop state as each sample leaves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Capture the response
  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

@@ design/pidt_checker.sv @@
module pidt_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input pidt_pkg::pidt_rsp_t             out_rsp_o,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [pidt_pkg::PaddrWidth-1:0] paddr,
  input logic [pidt_pkg::PdataWidth-1:0] pwdata,
  input logic [pidt_pkg::PdataWidth-1:0] prdata
);
  import pidt_pkg::*;

  logic cfg_wr_known;

  assign cfg_wr_known = psel && penable && pwrite
                     && (paddr[PaddrWidth-1:2] <= RegLower);

  // Requests stall only behind a blocked response
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("request stalled while response path is free");

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_rsp_o)))
    else $error("stalled response dropped or changed");

  // A written register reads back
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr_known ##1 (paddr == $past(paddr)) |-> (prdata == $past(pwdata)))
    else $error("register readback mismatch");

endmodule

bind pid_tustin_conditional_integral pidt_checker u_pidt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_rsp_o  (out_rsp_o),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .paddr      (paddr),
  .pwdata     (pwdata),
  .prdata     (prdata)
);
